/* rtl/sorted_set_table_macros.svh */
// Assertion macros used by the file that checks the sorted set table.
`ifndef SORTED_SET_TABLE_MACROS_SVH
`define SORTED_SET_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SST_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/sst_pkg.sv */
package sst_pkg;

   localparam int DEPTH = 32;
   localparam int CountWidth = $clog2(DEPTH + 1);

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   typedef enum logic [2:0] {
      STAT_INSERTED  = 3'd0,
      STAT_DUPLICATE = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_DELETED   = 3'd3,
      STAT_NOT_FOUND = 3'd4,
      STAT_FOUND     = 3'd5
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_UPDATE
   } state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } dp_cmd_type;

endpackage

/* rtl/sst_channels.sv */
interface sst_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic signed [31:0] item_value;

   modport source (output valid, output req_type, output item_value, input ready);
   modport sink (input valid, input req_type, input item_value, output ready);
endinterface

interface sst_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [5:0] entry_count;

   modport source (output valid, output status, output entry_count, input ready);
   modport sink (input valid, input status, input entry_count, output ready);
endinterface

/* rtl/sorted_set_table.sv */
// Sorted set table: holds up to 32 distinct signed 32-bit values in ascending
// order and serves insert, delete and search requests, one response per
// request that carries a status and the entry count after the request. In
// the cycle of its transfer a request is compared against every held entry
// at once and the result is registered; then, in the update state, the table
// shifts up or down by one entry where the request changes it and the
// response register is loaded. That update waits while the response
// register still holds an untaken response; no new request is taken until
// it ends. Reset empties the table by zeroing its count, with no clearing pass.
`include "sorted_set_table_macros.svh"

module sorted_set_table (
   input logic        clock,
   input logic        reset,
   sst_req_if.sink    req_if,
   sst_rsp_if.source  rsp_if
);

   sst_pkg::dp_cmd_type cmd;
   logic req_accept;
   logic ctrl_busy;
   logic rsp_full;
   logic full_count;
   logic rsp_inserted;
   logic rsp_nonzero;

   sst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .rsp_ready (rsp_if.ready),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .cmd       (cmd)
   );

   sst_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_type    (req_if.req_type),
      .item_value  (req_if.item_value),
      .status      (rsp_if.status),
      .entry_count (rsp_if.entry_count)
   );

   assign req_accept   = req_if.valid && req_if.ready;
   assign ctrl_busy    = !req_if.ready && !cmd.capture;
   assign rsp_full     = rsp_if.valid && (rsp_if.status == sst_pkg::STAT_FULL);
   assign full_count   = rsp_if.entry_count == 6'(sst_pkg::DEPTH);
   assign rsp_inserted = rsp_if.valid && (rsp_if.status == sst_pkg::STAT_INSERTED);
   assign rsp_nonzero  = rsp_if.entry_count != 6'd0;

   `SST_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, !req_if.ready, "busy accept")
   `SST_ASSERT_NEXT(a_commit_loads_rsp, clock, reset, cmd.commit, rsp_if.valid, "no response")
   `SST_ASSERT_SAME(a_commit_needs_capture, clock, reset, cmd.commit, ctrl_busy, "stray commit")
   `SST_ASSERT_SAME(a_full_count, clock, reset, rsp_full, full_count, "full below capacity")
   `SST_ASSERT_SAME(a_insert_count, clock, reset, rsp_inserted, rsp_nonzero, "empty after insert")

endmodule

/* rtl/sst_ctrl.sv */
module sst_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                rsp_ready,
   output logic                req_ready,
   output logic                rsp_valid,
   output sst_pkg::dp_cmd_type cmd
);

   sst_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sst_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         sst_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = sst_pkg::S_UPDATE;
            end
         end
         sst_pkg::S_UPDATE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = sst_pkg::S_IDLE;
            end
         end
      endcase
      rsp_valid_in = cmd.commit | (rsp_valid_ff & ~rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/sst_datapath.sv */
module sst_datapath (
   input  logic                clock,
   input  logic                reset,
   input  sst_pkg::dp_cmd_type cmd,
   input  logic [1:0]          req_type,
   input  logic signed [31:0]  item_value,
   output logic [2:0]          status,
   output logic [5:0]          entry_count
);

   localparam int Depth = sst_pkg::DEPTH;
   localparam int CountWidth = sst_pkg::CountWidth;

   logic signed [31:0] entries_ff [Depth];
   logic signed [31:0] entries_in [Depth];
   logic signed [31:0] prev_entry [Depth];
   logic signed [31:0] next_entry [Depth];
   logic [Depth-1:0] held;
   logic [Depth-1:0] below_now;
   logic [Depth-1:0] match_now;
   logic [Depth-1:0] ins_slot;
   logic [Depth-1:0] below_ff, below_in;
   logic hit_ff, hit_in;
   logic [1:0] op_ff, op_in;
   logic signed [31:0] value_ff, value_in;
   logic [CountWidth-1:0] count_ff, count_in;
   sst_pkg::status_type status_ff, status_in;
   logic [5:0] entry_count_ff, entry_count_in;
   logic do_insert;
   logic do_delete;

   // Every held entry is compared against the incoming value in parallel.
   for (genvar gi = 0; gi < Depth; gi++) begin : g_cell
      assign held[gi]      = CountWidth'(gi) < count_ff;
      assign below_now[gi] = held[gi] && (entries_ff[gi] < item_value);
      assign match_now[gi] = held[gi] && (entries_ff[gi] == item_value);

      if (gi == 0) begin : g_first
         assign ins_slot[gi]   = ~below_ff[gi];
         assign prev_entry[gi] = value_ff;
      end else begin : g_rest
         assign ins_slot[gi]   = ~below_ff[gi] & below_ff[gi-1];
         assign prev_entry[gi] = entries_ff[gi-1];
      end

      if (gi == Depth - 1) begin : g_last
         assign next_entry[gi] = entries_ff[gi];
      end else begin : g_inner
         assign next_entry[gi] = entries_ff[gi+1];
      end

      always_comb begin
         priority if (cmd.commit && do_insert && !below_ff[gi]) begin
            entries_in[gi] = ins_slot[gi] ? value_ff : prev_entry[gi];
         end else if (cmd.commit && do_delete && !below_ff[gi]) begin
            entries_in[gi] = next_entry[gi];
         end else begin
            entries_in[gi] = entries_ff[gi];
         end
      end

      always_ff @(posedge clock) begin
         entries_ff[gi] <= entries_in[gi];
      end
   end

   always_comb begin
      below_in = cmd.capture ? below_now : below_ff;
      hit_in   = cmd.capture ? |match_now : hit_ff;
      op_in    = cmd.capture ? req_type : op_ff;
      value_in = cmd.capture ? item_value : value_ff;

      do_insert = (op_ff == sst_pkg::OP_INSERT) && !hit_ff
                  && (count_ff < CountWidth'(Depth));
      do_delete = (op_ff == sst_pkg::OP_DELETE) && hit_ff;

      priority if (op_ff == sst_pkg::OP_INSERT) begin
         priority if (hit_ff) begin
            status_in = sst_pkg::STAT_DUPLICATE;
         end else if (!do_insert) begin
            status_in = sst_pkg::STAT_FULL;
         end else begin
            status_in = sst_pkg::STAT_INSERTED;
         end
      end else if (op_ff == sst_pkg::OP_DELETE) begin
         status_in = hit_ff ? sst_pkg::STAT_DELETED : sst_pkg::STAT_NOT_FOUND;
      end else begin
         status_in = hit_ff ? sst_pkg::STAT_FOUND : sst_pkg::STAT_NOT_FOUND;
      end

      priority if (cmd.commit && do_insert) begin
         count_in = count_ff + CountWidth'(1);
      end else if (cmd.commit && do_delete) begin
         count_in = count_ff - CountWidth'(1);
      end else begin
         count_in = count_ff;
      end

      entry_count_in = cmd.commit ? 6'(count_in) : entry_count_ff;
      if (!cmd.commit) begin
         status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      below_ff       <= below_in;
      hit_ff         <= hit_in;
      op_ff          <= op_in;
      value_ff       <= value_in;
      status_ff      <= status_in;
      entry_count_ff <= entry_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status      = status_ff;
   assign entry_count = entry_count_ff;

endmodule
